/* sv/wavrp_pkg.sv */
// Shared types and constants for the WAV RIFF header parser.
// No dependencies; used by wavrp_parser and the wav_riff_header_parser top level.
package wavrp_pkg;

    localparam logic [31:0] MAX_FMT_BYTES = 32'd64;

    // Chunk tags as little-endian words
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;

    // Result status codes
    localparam logic [1:0] STATUS_HEADER  = 2'd0;
    localparam logic [1:0] STATUS_PAYLOAD = 2'd1;
    localparam logic [1:0] STATUS_ERROR   = 2'd2;

    typedef struct packed {
        logic [31:0] riff_total_length;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [15:0] format_tag;
        logic [7:0]  payload_byte;
        logic        header_ready;
        logic [1:0]  status;
    } result_t;

endpackage

/* sv/wavrp_parser.sv */
// Parse state registers and per-byte next-state logic of the WAV header parser.
// Depends on wavrp_pkg for tags, status codes and the result type.
module wavrp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        stream_byte,
    input  logic              end_of_stream,
    output wavrp_pkg::result_t result
);

    typedef enum logic [5:0] {
        PH_RIFF    = 6'b000001,
        PH_CHUNK   = 6'b000010,
        PH_FMT     = 6'b000100,
        PH_SKIP    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_ERROR   = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  byte_cnt_reg, byte_cnt_next;
    logic [31:0] chunk_tag_reg, chunk_tag_next;
    logic [31:0] chunk_len_reg, chunk_len_next;
    logic [15:0] format_reg, format_next;
    logic [15:0] channels_reg, channels_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] riff_len_reg, riff_len_next;
    logic [8:0]  fmt_cnt_inc;
    logic [1:0]  status;
    logic        ready;
    logic [7:0]  pay;

    function automatic logic [31:0] put_byte32(input logic [31:0] word,
                                               input logic [1:0]  pos,
                                               input logic [7:0]  b);
        logic [31:0] w;
        w = word;
        w[pos*8 +: 8] = b;
        return w;
    endfunction

    function automatic logic [15:0] put_byte16(input logic [15:0] word,
                                               input logic        pos,
                                               input logic [7:0]  b);
        logic [15:0] w;
        w = word;
        w[pos*8 +: 8] = b;
        return w;
    endfunction

    assign fmt_cnt_inc = {1'b0, byte_cnt_reg} + 9'd1;

    always_comb begin
        phase_next     = phase_reg;
        byte_cnt_next  = byte_cnt_reg;
        chunk_tag_next = chunk_tag_reg;
        chunk_len_next = chunk_len_reg;
        format_next    = format_reg;
        channels_next  = channels_reg;
        rate_next      = rate_reg;
        riff_len_next  = riff_len_reg;
        status         = wavrp_pkg::STATUS_HEADER;
        ready          = 1'b0;
        pay            = 8'd0;

        unique case (phase_reg)
            PH_RIFF: begin
                if (byte_cnt_reg >= 8'd4 && byte_cnt_reg < 8'd8) begin
                    riff_len_next = put_byte32(riff_len_reg, byte_cnt_reg[1:0], stream_byte);
                end
                if (byte_cnt_reg >= 8'd11) begin
                    riff_len_next = riff_len_reg + 32'd8;
                    byte_cnt_next = 8'd0;
                    phase_next    = PH_CHUNK;
                end else begin
                    byte_cnt_next = byte_cnt_reg + 8'd1;
                end
            end
            PH_CHUNK: begin
                if (byte_cnt_reg < 8'd4) begin
                    chunk_tag_next = put_byte32(chunk_tag_reg, byte_cnt_reg[1:0], stream_byte);
                end else begin
                    chunk_len_next = put_byte32(chunk_len_reg, byte_cnt_reg[1:0], stream_byte);
                end
                if (byte_cnt_reg >= 8'd7) begin
                    byte_cnt_next = 8'd0;
                    if (chunk_tag_next == wavrp_pkg::TAG_FMT) begin
                        if (chunk_len_next > wavrp_pkg::MAX_FMT_BYTES) begin
                            phase_next = PH_ERROR;
                            status     = wavrp_pkg::STATUS_ERROR;
                        end else if (chunk_len_next == 32'd0) begin
                            phase_next = PH_CHUNK;
                        end else begin
                            phase_next = PH_FMT;
                        end
                    end else if (chunk_tag_next == wavrp_pkg::TAG_DATA) begin
                        phase_next = PH_PAYLOAD;
                        ready      = 1'b1;
                    end else begin
                        phase_next = (chunk_len_next == 32'd0) ? PH_CHUNK : PH_SKIP;
                    end
                end else begin
                    byte_cnt_next = byte_cnt_reg + 8'd1;
                end
            end
            PH_FMT: begin
                if (byte_cnt_reg < 8'd2) begin
                    format_next = put_byte16(format_reg, byte_cnt_reg[0], stream_byte);
                end else if (byte_cnt_reg < 8'd4) begin
                    channels_next = put_byte16(channels_reg, byte_cnt_reg[0], stream_byte);
                end else if (byte_cnt_reg < 8'd8) begin
                    rate_next = put_byte32(rate_reg, byte_cnt_reg[1:0], stream_byte);
                end
                if ({23'd0, fmt_cnt_inc} >= chunk_len_reg) begin
                    byte_cnt_next = 8'd0;
                    phase_next    = PH_CHUNK;
                end else begin
                    byte_cnt_next = fmt_cnt_inc[7:0];
                end
            end
            PH_SKIP: begin
                chunk_len_next = chunk_len_reg - 32'd1;
                if (chunk_len_next == 32'd0) begin
                    phase_next = PH_CHUNK;
                end
            end
            PH_PAYLOAD: begin
                status = wavrp_pkg::STATUS_PAYLOAD;
                pay    = stream_byte;
            end
            default: begin
                phase_next = PH_ERROR;
                status     = wavrp_pkg::STATUS_ERROR;
            end
        endcase

        // End of stream short of the payload is an error
        if (end_of_stream && phase_next != PH_PAYLOAD) begin
            status = wavrp_pkg::STATUS_ERROR;
            pay    = 8'd0;
        end
    end

    always_comb begin
        result.status            = status;
        result.header_ready      = ready;
        result.payload_byte      = pay;
        result.format_tag        = format_next;
        result.channel_count     = channels_next;
        result.sample_rate       = rate_next;
        result.riff_total_length = riff_len_next;
    end

    // Return to the RIFF header on reset or after the last byte of a file
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && end_of_stream)) begin
            phase_reg     <= PH_RIFF;
            byte_cnt_reg  <= 8'd0;
            chunk_tag_reg <= 32'd0;
            chunk_len_reg <= 32'd0;
            format_reg    <= 16'd0;
            channels_reg  <= 16'd0;
            rate_reg      <= 32'd0;
            riff_len_reg  <= 32'd0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            byte_cnt_reg  <= byte_cnt_next;
            chunk_tag_reg <= chunk_tag_next;
            chunk_len_reg <= chunk_len_next;
            format_reg    <= format_next;
            channels_reg  <= channels_next;
            rate_reg      <= rate_next;
            riff_len_reg  <= riff_len_next;
        end
    end

`ifndef SYNTHESIS
    a_eos_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && end_of_stream |=> phase_reg == PH_RIFF && byte_cnt_reg == 8'd0)
        else $error("parser did not restart after end of stream");

    a_fmt_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_FMT |-> {24'd0, byte_cnt_reg} < chunk_len_reg
            && chunk_len_reg <= wavrp_pkg::MAX_FMT_BYTES)
        else $error("fmt byte counter past chunk length");

    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SKIP |-> chunk_len_reg != 32'd0)
        else $error("skip phase with zero remaining length");

    a_ready_enters_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && result.header_ready && !end_of_stream |=> phase_reg == PH_PAYLOAD)
        else $error("data header completed without entering payload");
`endif

endmodule

/* sv/wav_riff_header_parser.sv */
// A result appears on the master side in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the master stalls; the output refills as taken.
// Every accepted byte yields exactly one result.
// Reset: aresetn low at a rising edge clears the parse state and empties the output.
// Top level of the WAV header parser; depends on wavrp_pkg and wavrp_parser.
module wav_riff_header_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] stream_byte
    input  logic         s_axis_tlast,   // end_of_stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] payload_byte, [23:8] format_tag, [39:24] channel_count,
    // [71:40] sample_rate, [103:72] riff_total_length
    output logic [103:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser    // [1:0] status, [2] header_ready
);

    wavrp_pkg::result_t result;
    wavrp_pkg::result_t out_reg;
    logic               out_valid_reg;
    logic               accept;

    // Take a new request whenever the output register is empty or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    wavrp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .stream_byte   (s_axis_tdata),
        .end_of_stream (s_axis_tlast),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.riff_total_length, out_reg.sample_rate,
                            out_reg.channel_count, out_reg.format_tag,
                            out_reg.payload_byte};
    assign m_axis_tuser  = {out_reg.header_ready, out_reg.status};

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for wav_riff_header_parser: streams WAV files byte by byte and checks
// every result against a parser model kept here. Depends on wavrp_pkg and the RTL.
module tb;

    typedef enum logic [5:0] {
        PS_RIFF      = 6'b000001,
        PS_CHUNK_HDR = 6'b000010,
        PS_FMT_BODY  = 6'b000100,
        PS_SKIP_BODY = 6'b001000,
        PS_PAYLOAD   = 6'b010000,
        PS_ERROR     = 6'b100000
    } parse_state_t;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_pattern_t;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;
    localparam int unsigned RANDOM_BYTES = 1230;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned FILE_DEPTH = 512;
    localparam int unsigned EXP_DEPTH = 16;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'd0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    wav_riff_header_parser u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Parser model state
    parse_state_t pm_state;
    logic [7:0]   pm_count;
    logic [31:0]  pm_tag;
    logic [31:0]  pm_len;
    logic [15:0]  pm_format;
    logic [15:0]  pm_channels;
    logic [31:0]  pm_rate;
    logic [31:0]  pm_riff_len;

    // Expected results, written by the sender and read by the checker
    wavrp_pkg::result_t exp_fifo[0:EXP_DEPTH-1];
    int unsigned        exp_wr = 0;
    int unsigned        exp_rd = 0;
    logic [7:0]         file_bytes[0:FILE_DEPTH-1];
    int unsigned        file_len = 0;
    int unsigned        n_errors = 0;
    int unsigned        bytes_sent = 0;
    int unsigned        burst_left = 0;
    bit                 gaps_on = 1'b0;
    rx_pattern_t        rx_mode = RX_ALWAYS;
    int unsigned        rx_tick = 0;

    function automatic void clear_parser();
        pm_state    = PS_RIFF;
        pm_count    = 8'd0;
        pm_tag      = 32'd0;
        pm_len      = 32'd0;
        pm_format   = 16'd0;
        pm_channels = 16'd0;
        pm_rate     = 32'd0;
        pm_riff_len = 32'd0;
    endfunction

    function automatic wavrp_pkg::result_t parse_byte(input logic [7:0] b, input logic eos);
        wavrp_pkg::result_t r;
        r = '0;
        r.status = wavrp_pkg::STATUS_HEADER;
        case (pm_state)
            PS_RIFF: begin
                if (pm_count >= 8'd4 && pm_count < 8'd8)
                    pm_riff_len[8*pm_count[1:0] +: 8] = b;
                if (pm_count >= 8'd11) begin
                    pm_riff_len = pm_riff_len + 32'd8;
                    pm_count    = 8'd0;
                    pm_state    = PS_CHUNK_HDR;
                end else begin
                    pm_count = pm_count + 8'd1;
                end
            end
            PS_CHUNK_HDR: begin
                if (pm_count < 8'd4)
                    pm_tag[8*pm_count[1:0] +: 8] = b;
                else
                    pm_len[8*pm_count[1:0] +: 8] = b;
                if (pm_count >= 8'd7) begin
                    pm_count = 8'd0;
                    if (pm_tag == wavrp_pkg::TAG_FMT) begin
                        if (pm_len > wavrp_pkg::MAX_FMT_BYTES) begin
                            pm_state = PS_ERROR;
                            r.status = wavrp_pkg::STATUS_ERROR;
                        end else if (pm_len == 32'd0) begin
                            pm_state = PS_CHUNK_HDR;
                        end else begin
                            pm_state = PS_FMT_BODY;
                        end
                    end else if (pm_tag == wavrp_pkg::TAG_DATA) begin
                        pm_state = PS_PAYLOAD;
                        r.header_ready = 1'b1;
                    end else begin
                        pm_state = (pm_len == 32'd0) ? PS_CHUNK_HDR : PS_SKIP_BODY;
                    end
                end else begin
                    pm_count = pm_count + 8'd1;
                end
            end
            PS_FMT_BODY: begin
                if (pm_count < 8'd2)
                    pm_format[8*pm_count[0] +: 8] = b;
                else if (pm_count < 8'd4)
                    pm_channels[8*pm_count[0] +: 8] = b;
                else if (pm_count < 8'd8)
                    pm_rate[8*pm_count[1:0] +: 8] = b;
                if ({24'd0, pm_count} + 32'd1 >= pm_len) begin
                    pm_count = 8'd0;
                    pm_state = PS_CHUNK_HDR;
                end else begin
                    pm_count = pm_count + 8'd1;
                end
            end
            PS_SKIP_BODY: begin
                pm_len = pm_len - 32'd1;
                if (pm_len == 32'd0)
                    pm_state = PS_CHUNK_HDR;
            end
            PS_PAYLOAD: begin
                r.status       = wavrp_pkg::STATUS_PAYLOAD;
                r.payload_byte = b;
            end
            default: begin
                pm_state = PS_ERROR;
                r.status = wavrp_pkg::STATUS_ERROR;
            end
        endcase
        if (eos && pm_state != PS_PAYLOAD) begin
            r.status       = wavrp_pkg::STATUS_ERROR;
            r.payload_byte = 8'd0;
        end
        r.format_tag        = pm_format;
        r.channel_count     = pm_channels;
        r.sample_rate       = pm_rate;
        r.riff_total_length = pm_riff_len;
        if (eos)
            clear_parser();
        return r;
    endfunction

    // File builders: append little-endian words and chunks to file_bytes
    function automatic void add_byte(input logic [7:0] b);
        file_bytes[file_len[8:0]] = b;
        file_len++;
    endfunction

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            add_byte(w[8*i +: 8]);
    endfunction

    function automatic void put_riff(input logic [31:0] size);
        put_word(TAG_RIFF);
        put_word(size);
        put_word(TAG_WAVE);
    endfunction

    function automatic void put_chunk_hdr(input logic [31:0] tag, input logic [31:0] len);
        put_word(tag);
        put_word(len);
    endfunction

    function automatic void put_noise(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            add_byte(8'($urandom));
    endfunction

    function automatic void put_fmt(input logic [31:0] len, input logic [15:0] fmt_code,
                                    input logic [15:0] chans, input logic [31:0] rate);
        logic [63:0] body;
        body = {rate, chans, fmt_code};
        put_chunk_hdr(wavrp_pkg::TAG_FMT, len);
        for (int i = 0; i < len; i++)
            add_byte(i < 8 ? body[8*i +: 8] : 8'($urandom));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int unsigned gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (burst_left != 0)
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        exp_fifo[exp_wr[3:0]] = parse_byte(b, eos);
        exp_wr++;
        bytes_sent++;
    endtask

    // Send the first count bytes of the built file, end of stream on the last one
    task automatic send_file(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_byte(file_bytes[i[8:0]], i == count - 1);
        file_len = 0;
    endtask

    // Hold off the sender until every pending result has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge aclk);
        while (exp_wr != exp_rd);
    endtask

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_ALWAYS:   m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_axis_tready <= (rx_tick % 7) >= 3;
            default:     m_axis_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge aclk) begin : check_results
        wavrp_pkg::result_t got;
        wavrp_pkg::result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tuser};
            if (exp_wr == exp_rd) begin
                if (n_errors < MAX_REPORTS)
                    $display("%0t: result with no request pending, tdata %h tuser %h",
                             $realtime, m_axis_tdata, m_axis_tuser);
                n_errors++;
            end else begin
                want = exp_fifo[exp_rd[3:0]];
                exp_rd++;
                if (got.status != want.status || got.header_ready != want.header_ready ||
                    got.payload_byte != want.payload_byte ||
                    got.format_tag != want.format_tag ||
                    got.channel_count != want.channel_count ||
                    got.sample_rate != want.sample_rate ||
                    got.riff_total_length != want.riff_total_length) begin
                    if (n_errors < MAX_REPORTS)
                        $display({"%0t: mismatch (expected/actual) status %0d/%0d ready %0b/%0b",
                                  " payload %h/%h format %h/%h channels %h/%h",
                                  " rate %h/%h riff %h/%h"},
                                 $realtime, want.status, got.status,
                                 want.header_ready, got.header_ready,
                                 want.payload_byte, got.payload_byte,
                                 want.format_tag, got.format_tag,
                                 want.channel_count, got.channel_count,
                                 want.sample_rate, got.sample_rate,
                                 want.riff_total_length, got.riff_total_length);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_header_extremes();
        // RIFF size wraps; end of stream on the last data header byte
        put_riff(32'hFFFF_FFFF);
        put_chunk_hdr(wavrp_pkg::TAG_DATA, 32'd0);
        send_file(file_len);
        put_riff(32'd0);
        put_fmt(32'd16, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
        put_chunk_hdr(wavrp_pkg::TAG_DATA, 32'hFFFF_FFFF);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h5A);
        send_file(file_len);
    endtask

    task automatic test_fmt_chunks();
        // Empty, short, full-size and repeated fmt chunks
        put_riff(32'h0000_1234);
        put_fmt(32'd0, 16'h1111, 16'h2222, 32'h3333_3333);
        put_fmt(32'd3, 16'h0001, 16'hABCD, 32'h4444_4444);
        put_fmt(wavrp_pkg::MAX_FMT_BYTES, 16'hFFFE, 16'h0006, 32'h0002_EE00);
        put_fmt(32'd8, 16'h0003, 16'h0002, 32'h0000_AC44);
        put_chunk_hdr(wavrp_pkg::TAG_DATA, 32'd1);
        add_byte(8'hC3);
        send_file(file_len);
    endtask

    task automatic test_fmt_oversize();
        put_riff(32'd36);
        put_chunk_hdr(wavrp_pkg::TAG_FMT, wavrp_pkg::MAX_FMT_BYTES + 32'd1);
        put_noise(4);
        send_file(file_len);
        put_riff(32'd36);
        put_chunk_hdr(wavrp_pkg::TAG_FMT, 32'hFFFF_FFFF);
        put_chunk_hdr(wavrp_pkg::TAG_DATA, 32'd4);
        send_file(file_len);
    endtask

    task automatic test_skipped_chunks();
        put_riff(32'd100);
        put_chunk_hdr(TAG_LIST, 32'd0);
        put_chunk_hdr(32'hDEAD_BEEF, 32'd5);
        put_noise(5);
        put_chunk_hdr(wavrp_pkg::TAG_DATA ^ 32'h0000_0100, 32'd2);
        put_noise(2);
        put_chunk_hdr(wavrp_pkg::TAG_DATA, 32'd2);
        put_noise(2);
        send_file(file_len);
    endtask

    task automatic test_early_end();
        add_byte(8'h52);
        send_file(1);
        put_riff(32'h0102_0304);
        send_file(7);
        put_riff(32'd8);
        put_chunk_hdr(wavrp_pkg::TAG_DATA, 32'd0);
        send_file(18);
        put_riff(32'd60);
        put_fmt(32'd16, 16'h0001, 16'h0002, 32'd48000);
        send_file(25);
        // Huge skip length: the stream ends long before the chunk does
        put_riff(32'd60);
        put_chunk_hdr(TAG_LIST, 32'hFFFF_FFFF);
        put_noise(3);
        send_file(file_len);
    endtask

    task automatic test_random_files();
        int unsigned stop_at;
        int unsigned n_files;
        int unsigned kind;
        int unsigned n_chunks;
        int unsigned pick;
        logic [31:0] size;
        logic [31:0] len;
        stop_at = bytes_sent + RANDOM_BYTES;
        n_files = 0;
        while (bytes_sent < stop_at) begin
            if (n_files % 25 == 0) begin
                rx_mode = rx_pattern_t'($urandom_range(0, 3));
                gaps_on = $urandom_range(0, 2) != 0;
            end
            if (n_files == 40)
                wait_for_results();
            n_files++;
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                put_noise($urandom_range(1, 40));
                send_file(file_len);
                continue;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
                size = 32'hFFFF_FFFF - $urandom_range(0, 8);
            else if (pick == 1)
                size = $urandom_range(0, 8);
            else
                size = $urandom;
            put_riff(size);
            n_chunks = $urandom_range(0, 3);
            for (int unsigned c = 0; c < n_chunks; c++) begin
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        len = 32'd0;
                    else if (pick == 1)
                        len = $urandom_range(1, wavrp_pkg::MAX_FMT_BYTES);
                    else
                        len = $urandom_range(1, 20);
                    put_fmt(len, 16'($urandom), 16'($urandom), $urandom);
                end else begin
                    len = $urandom_range(0, 12);
                    if (pick == 9)
                        put_chunk_hdr(wavrp_pkg::TAG_FMT ^ (32'd1 << $urandom_range(0, 31)),
                                      len);
                    else if (pick == 8)
                        put_chunk_hdr(wavrp_pkg::TAG_DATA ^ (32'd1 << $urandom_range(0, 31)),
                                      len);
                    else
                        put_chunk_hdr($urandom, len);
                    put_noise(len);
                end
            end
            if (kind < 14) begin
                pick = $urandom_range(0, 1);
                put_chunk_hdr(wavrp_pkg::TAG_FMT,
                              pick ? 32'($urandom) | 32'h0000_0100
                                   : wavrp_pkg::MAX_FMT_BYTES + $urandom_range(1, 191));
                put_noise($urandom_range(0, 6));
            end else begin
                put_chunk_hdr(wavrp_pkg::TAG_DATA, $urandom);
                put_noise($urandom_range(0, 3) == 0 ? $urandom_range(0, 2)
                                                    : $urandom_range(1, 24));
            end
            // Cut some files short at a random byte
            if (kind >= 14 && kind < 26)
                send_file($urandom_range(1, file_len));
            else
                send_file(file_len);
        end
    endtask

    initial begin
        clear_parser();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_header_extremes();
        rx_mode = RX_PERIODIC;
        gaps_on = 1'b1;
        test_fmt_chunks();
        test_fmt_oversize();
        rx_mode = RX_RANDOM;
        test_skipped_chunks();
        test_early_end();
        wait_for_results();
        test_random_files();
        wait_for_results();
        repeat (8) @(posedge aclk);
        if (n_errors == 0 && exp_wr == exp_rd) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
